[rtl/json_byte_tokenizer_unit_defines.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef JSON_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define JBT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define JBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jbt_pkg.sv]
// Shared types and constants of the JSON byte tokenizer.
`default_nettype none
package jbt_pkg;

  localparam int IN_DATA_W       = 8;
  localparam int OUT_DATA_W      = 16;
  localparam int KIND_W          = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Input kind codes.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Token kind codes.
  localparam logic [3:0] TK_LBRACE   = 4'd0;
  localparam logic [3:0] TK_RBRACE   = 4'd1;
  localparam logic [3:0] TK_LBRACKET = 4'd2;
  localparam logic [3:0] TK_RBRACKET = 4'd3;
  localparam logic [3:0] TK_KEY_SEP  = 4'd4;
  localparam logic [3:0] TK_ELEM_SEP = 4'd5;
  localparam logic [3:0] TK_STRING   = 4'd6;
  localparam logic [3:0] TK_NUMBER   = 4'd7;
  localparam logic [3:0] TK_TRUE     = 4'd8;
  localparam logic [3:0] TK_KW_FALSE = 4'd9;
  localparam logic [3:0] TK_NULL     = 4'd10;
  localparam logic [3:0] TK_END      = 4'd11;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHAR    = 2'd1;
  localparam logic [1:0] ERR_KEYWORD = 2'd2;

  // Characters with a role of their own.
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_POINT    = 8'h2E;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  // Keyword slots; candidate bit i belongs to slot i.
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  // One result item.
  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_done;
    logic [1:0] error_code;
    logic       last_of_run;
  } res_t;

  // Results of one accepted input, handed from the lexer to the queue.
  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage
`default_nettype wire

[rtl/jbt_lexer.sv]
// Lexer state machine: turns one accepted input into up to two results.
`default_nettype none
`include "json_byte_tokenizer_unit_defines.svh"
module jbt_lexer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic           in_kind,
  input  wire logic [7:0]     in_byte,
  output jbt_pkg::push_t      push
);
  import jbt_pkg::*;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_STR  = 6'b000010,
    MODE_ESC  = 6'b000100,
    MODE_NUM  = 6'b001000,
    MODE_KW   = 6'b010000,
    MODE_ERR  = 6'b100000
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic       seen_point_r, seen_point_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] cand_r, cand_nxt;

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] b, logic valid,
                                  logic done, logic [1:0] err);
    res_t r;
    r.token_kind  = kind;
    r.out_byte    = valid ? b : 8'd0;
    r.byte_valid  = valid;
    r.token_done  = done;
    r.error_code  = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] k);
    return (k == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  // Letter of keyword k at position pos; zero past the end.
  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] pos);
    logic [7:0] r;
    r = 8'd0;
    unique case (k)
      KW_TRUE: begin
        case (pos)
          3'd0: r = 8'h74;
          3'd1: r = 8'h72;
          3'd2: r = 8'h75;
          3'd3: r = 8'h65;
          default: r = 8'd0;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0: r = 8'h66;
          3'd1: r = 8'h61;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h73;
          3'd4: r = 8'h65;
          default: r = 8'd0;
        endcase
      end
      KW_NULL: begin
        case (pos)
          3'd0: r = 8'h6E;
          3'd1: r = 8'h75;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h6C;
          default: r = 8'd0;
        endcase
      end
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Outcome of a byte seen between tokens.
  res_t       idle_res;
  logic       idle_hit;
  mode_t      idle_mode;
  logic       idle_num;
  logic       idle_kw;
  logic [2:0] idle_cand;

  always_comb begin
    idle_res  = '0;
    idle_hit  = 1'b0;
    idle_mode = MODE_IDLE;
    idle_num  = 1'b0;
    idle_kw   = 1'b0;
    idle_cand = {in_byte == kw_char(KW_NULL, 3'd0), in_byte == kw_char(KW_FALSE, 3'd0),
                 in_byte == kw_char(KW_TRUE, 3'd0)};
    case (in_byte) inside
      CH_LBRACE: begin
        idle_hit = 1'b1;
        idle_res = mk_res(TK_LBRACE, in_byte, 1'b1, 1'b1, ERR_NONE);
      end
      CH_RBRACE: begin
        idle_hit = 1'b1;
        idle_res = mk_res(TK_RBRACE, in_byte, 1'b1, 1'b1, ERR_NONE);
      end
      CH_LBRACKET: begin
        idle_hit = 1'b1;
        idle_res = mk_res(TK_LBRACKET, in_byte, 1'b1, 1'b1, ERR_NONE);
      end
      CH_RBRACKET: begin
        idle_hit = 1'b1;
        idle_res = mk_res(TK_RBRACKET, in_byte, 1'b1, 1'b1, ERR_NONE);
      end
      CH_COLON: begin
        idle_hit = 1'b1;
        idle_res = mk_res(TK_KEY_SEP, in_byte, 1'b1, 1'b1, ERR_NONE);
      end
      CH_COMMA: begin
        idle_hit = 1'b1;
        idle_res = mk_res(TK_ELEM_SEP, in_byte, 1'b1, 1'b1, ERR_NONE);
      end
      CH_QUOTE: idle_mode = MODE_STR;
      CH_SPACE, [8'h09:8'h0D]: idle_mode = MODE_IDLE;
      CH_MINUS, CH_PLUS, [8'h30:8'h39]: begin
        idle_hit  = 1'b1;
        idle_mode = MODE_NUM;
        idle_num  = 1'b1;
        idle_res  = mk_res(TK_NUMBER, in_byte, 1'b1, 1'b0, ERR_NONE);
      end
      [8'h41:8'h5A], [8'h61:8'h7A]: begin
        idle_mode = MODE_KW;
        idle_kw   = 1'b1;
      end
      default: begin
        idle_hit  = 1'b1;
        idle_mode = MODE_ERR;
        idle_res  = mk_res(TK_LBRACE, 8'd0, 1'b0, 1'b0, ERR_CHAR);
      end
    endcase
  end

  // Keyword step and keyword close.
  logic [2:0] take_cand;
  logic [2:0] take_cnt;
  logic       kw_ok;
  res_t       kw_res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      take_cand[i] = cand_r[i] && (cnt_r < kw_len(2'(i))) && (kw_char(2'(i), cnt_r) == in_byte);
    end
    take_cnt = (cnt_r == 3'd7) ? cnt_r : cnt_r + 3'd1;
    kw_ok  = 1'b1;
    if (cand_r[KW_TRUE] && cnt_r == kw_len(KW_TRUE)) begin
      kw_res = mk_res(TK_TRUE, 8'd0, 1'b0, 1'b1, ERR_NONE);
    end else if (cand_r[KW_FALSE] && cnt_r == kw_len(KW_FALSE)) begin
      kw_res = mk_res(TK_KW_FALSE, 8'd0, 1'b0, 1'b1, ERR_NONE);
    end else if (cand_r[KW_NULL] && cnt_r == kw_len(KW_NULL)) begin
      kw_res = mk_res(TK_NULL, 8'd0, 1'b0, 1'b1, ERR_NONE);
    end else begin
      kw_ok  = 1'b0;
      kw_res = mk_res(TK_LBRACE, 8'd0, 1'b0, 1'b0, ERR_KEYWORD);
    end
  end

  res_t       r0, r1;
  logic [1:0] n;

  always_comb begin
    mode_nxt       = mode_r;
    seen_point_nxt = seen_point_r;
    cnt_nxt        = cnt_r;
    cand_nxt       = cand_r;
    r0             = '0;
    r1             = '0;
    n              = 2'd0;
    if (accept) begin
      if (in_kind == KIND_END) begin
        unique case (mode_r)
          MODE_STR, MODE_ESC: begin
            r0 = mk_res(TK_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
            n  = 2'd1;
          end
          MODE_NUM: begin
            r0 = mk_res(TK_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
            n  = 2'd1;
          end
          MODE_KW: begin
            r0 = kw_res;
            n  = 2'd1;
          end
          default: n = 2'd0;
        endcase
        if (n == 2'd1) begin
          r1 = mk_res(TK_END, 8'd0, 1'b0, 1'b1, ERR_NONE);
          n  = 2'd2;
        end else begin
          r0 = mk_res(TK_END, 8'd0, 1'b0, 1'b1, ERR_NONE);
          n  = 2'd1;
        end
        mode_nxt       = MODE_IDLE;
        seen_point_nxt = 1'b0;
        cnt_nxt        = 3'd0;
        cand_nxt       = 3'b111;
      end else begin
        unique case (mode_r)
          MODE_STR: begin
            if (in_byte == CH_QUOTE) begin
              mode_nxt = MODE_IDLE;
              r0       = mk_res(TK_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
              n        = 2'd1;
            end else if (in_byte == CH_BSLASH) begin
              mode_nxt = MODE_ESC;
            end else begin
              r0 = mk_res(TK_STRING, in_byte, 1'b1, 1'b0, ERR_NONE);
              n  = 2'd1;
            end
          end
          MODE_ESC: begin
            mode_nxt = MODE_STR;
            r0       = mk_res(TK_STRING, unescape(in_byte), 1'b1, 1'b0, ERR_NONE);
            n        = 2'd1;
          end
          MODE_NUM: begin
            if (is_digit(in_byte) || (in_byte == CH_POINT && !seen_point_r)) begin
              if (in_byte == CH_POINT) seen_point_nxt = 1'b1;
              r0 = mk_res(TK_NUMBER, in_byte, 1'b1, 1'b0, ERR_NONE);
              n  = 2'd1;
            end else begin
              // The closing byte is handled again as if between tokens.
              r0       = mk_res(TK_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
              r1       = idle_res;
              n        = idle_hit ? 2'd2 : 2'd1;
              mode_nxt = idle_mode;
              if (idle_num) seen_point_nxt = 1'b0;
              if (idle_kw) begin
                cnt_nxt  = 3'd1;
                cand_nxt = idle_cand;
              end
            end
          end
          MODE_KW: begin
            if (is_letter(in_byte)) begin
              cand_nxt = take_cand;
              cnt_nxt  = take_cnt;
            end else begin
              r0 = kw_res;
              if (kw_ok) begin
                r1       = idle_res;
                n        = idle_hit ? 2'd2 : 2'd1;
                mode_nxt = idle_mode;
                if (idle_num) seen_point_nxt = 1'b0;
                if (idle_kw) begin
                  cnt_nxt  = 3'd1;
                  cand_nxt = idle_cand;
                end
              end else begin
                n        = 2'd1;
                mode_nxt = MODE_ERR;
              end
            end
          end
          MODE_ERR: n = 2'd0;
          default: begin
            r0       = idle_res;
            n        = idle_hit ? 2'd1 : 2'd0;
            mode_nxt = idle_mode;
            if (idle_num) seen_point_nxt = 1'b0;
            if (idle_kw) begin
              cnt_nxt  = 3'd1;
              cand_nxt = idle_cand;
            end
          end
        endcase
      end
    end
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign push.n    = n;
  assign push.res0 = r0;
  assign push.res1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      seen_point_r <= 1'b0;
      cnt_r        <= 3'd0;
      cand_r       <= 3'b111;
    end else begin
      mode_r       <= mode_nxt;
      seen_point_r <= seen_point_nxt;
      cnt_r        <= cnt_nxt;
      cand_r       <= cand_nxt;
    end
  end

  // A failed keyword closed by end of text is the one first result that is not a done token.
  `JBT_ASSERT_SAME(a_pair_closes_first, push.n == 2'd2, !push.res0.byte_valid && (push.res0.token_done || push.res0.error_code == ERR_KEYWORD), "first of two results must close a token")
  `JBT_ASSERT_SAME(a_last_marks_end, push.n != 2'd0, (push.n == 2'd1 && push.res0.last_of_run) || (push.n == 2'd2 && push.res1.last_of_run && !push.res0.last_of_run), "last flag misplaced")
  `JBT_ASSERT_SAME(a_err_silent, accept && mode_r == MODE_ERR && in_kind == KIND_BYTE, push.n == 2'd0, "byte in error mode gave a result")
  `JBT_ASSERT_NEXT(a_end_resets, accept && in_kind == KIND_END, mode_r == MODE_IDLE && cnt_r == 3'd0 && cand_r == 3'b111 && !seen_point_r, "end of text did not reset state")

endmodule
`default_nettype wire

[rtl/jbt_res_queue.sv]
// Result queue: takes up to two results per cycle and hands out one per transfer.
`default_nettype none
`include "json_byte_tokenizer_unit_defines.svh"
module jbt_res_queue #(
  parameter int DEPTH = jbt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire jbt_pkg::push_t                 push,
  output logic                                room,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [jbt_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [jbt_pkg::KIND_W-1:0]          out_tuser,
  output logic                                out_tlast
);
  import jbt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wr_ptr_1, wr_ptr_2;
  logic          pop;
  res_t          head;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr_1 = ptr_inc(wr_ptr_r);
  assign wr_ptr_2 = ptr_inc(wr_ptr_1);
  assign pop      = out_tvalid && out_tready;
  assign room     = cnt_r <= CW'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wr_ptr_r] <= push.res0;
    if (push.n == 2'd2) q_r[wr_ptr_1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.n == 2'd1) wr_ptr_r <= wr_ptr_1;
      else if (push.n == 2'd2) wr_ptr_r <= wr_ptr_2;
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      cnt_r <= cnt_r + CW'(push.n) - CW'(pop);
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tuser  = head.token_kind;
  assign out_tlast  = head.last_of_run;
  assign out_tdata  = {{(OUT_DATA_W - 12){1'b0}}, head.error_code, head.token_done,
                       head.byte_valid, head.out_byte};

  `JBT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "queue count above depth")
  `JBT_ASSERT_NEXT(a_cnt_up, push.n != 2'd0 && !pop, cnt_r == $past(cnt_r) + CW'($past(push.n)), "count did not follow pushes")
  `JBT_ASSERT_NEXT(a_cnt_down, push.n == 2'd0 && pop, cnt_r == $past(cnt_r) - CW'(1), "count did not follow transfer")

endmodule
`default_nettype wire

[rtl/json_byte_tokenizer_unit.sv]
// Top level of the streaming JSON byte tokenizer.
//
//  Channel | Dir | Fields (low bit first)
//  in_     | in  | tuser: kind (1=end of text); tdata: text_byte
//  out_    | out | tuser: token_kind; tdata: out_byte, byte_valid, token_done,
//          |     |   error_code, zero fill; tlast: last_of_run
//
// One text byte is taken per cycle while in_tready is high; its results are written to the queue at
// the same edge and appear on out_ from the next cycle on.
// A byte can give two results; the queue drains one per transfer, so in_tready
// drops while fewer than two queue entries are free.
// Synchronous active-low reset returns the lexer to idle and empties the queue.
// A stalled output keeps its data, and input is held off only once fewer than
// two queue entries are free.
`default_nettype none
module json_byte_tokenizer_unit #(
  parameter int QUEUE_DEPTH = jbt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [jbt_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] text_byte
  input  wire logic                           in_tuser,   // [0] kind
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [jbt_pkg::OUT_DATA_W-1:0]      out_tdata,  // [7:0] out_byte, [8] byte_valid,
                                                          // [9] token_done, [11:10] error_code
  output logic [jbt_pkg::KIND_W-1:0]          out_tuser,  // [3:0] token_kind
  output logic                                out_tlast
);
  import jbt_pkg::*;

  push_t push;
  logic  room;
  logic  accept;

  assign in_tready = room;
  assign accept    = in_tvalid && room;

  jbt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_kind (in_tuser),
    .in_byte (in_tdata),
    .push    (push)
  );

  jbt_res_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
